// ===== hw/rtl/spq_pkg.sv =====
`timescale 1ns / 1ps
package spq_pkg;

  localparam int DataW = 32;
  localparam int PriW  = 8;
  localparam int OccW  = 5;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  typedef enum logic {
    REQ_ENQ = 1'b0,
    REQ_DEQ = 1'b1
  } req_t;

  // contents of one cell
  typedef struct packed {
    logic             valid;
    logic [DataW-1:0] value;
    logic [PriW-1:0]  pri;
  } entry_t;

  // operation broadcast to every cell
  typedef struct packed {
    logic             enq;
    logic             deq;
    logic [DataW-1:0] value;
    logic [PriW-1:0]  pri;
  } cell_op_t;

  localparam logic [DataW-1:0] NoneData = '1;

endpackage

// ===== hw/rtl/sorted_priority_queue.sv =====
`timescale 1ns / 1ps
// The result of an input transfer is registered and appears on the m side in the next cycle.
// Throughput: one request per cycle while m_tready is high; the row of cells
// moves every entry (hold, shift or load) in the same cycle the request lands.
// A result waiting on m_tready holds off new requests until it is taken.
// Reset clears the cell valid bits, the entry count and the output valid.
module sorted_priority_queue
  import spq_pkg::*;
#(
  parameter int DEPTH = 16
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [39:0]  s_tdata,   // data_in[31:0], priority_in[39:32]
  input  logic         s_tuser,   // req_type[0]
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [103:0] m_tdata,   // removed_data[31:0], head_data[63:32],
                                  // tail_data[95:64], occupancy[100:96], zero pad
  output logic [1:0]   m_tuser    // status[1:0]
);

  localparam int CntW = $clog2(DEPTH + 1);

  logic [CntW-1:0]  count;
  logic [CntW-1:0]  count_next;
  logic [DataW-1:0] tail;
  logic [DataW-1:0] tail_next;
  logic [DataW-1:0] head_next;
  logic [DataW-1:0] removed_next;
  status_t          status_next;

  logic [DataW-1:0] data_in;
  logic [PriW-1:0]  priority_in;
  req_t             req_type;
  logic             xfer;
  logic             is_full;
  logic             is_empty;
  logic             at_end;

  entry_t           ents [DEPTH];
  logic [DEPTH-1:0] keeps;
  logic [DEPTH-1:0] open_slot;
  cell_op_t         op;

  logic [DataW-1:0] removed_data;
  logic [DataW-1:0] head_data;
  logic [DataW-1:0] tail_data;
  logic [OccW-1:0]  occupancy;
  status_t          status;

  assign data_in     = s_tdata[DataW-1:0];
  assign priority_in = s_tdata[DataW+PriW-1:DataW];
  assign req_type    = req_t'(s_tuser);

  assign s_tready = !m_tvalid || m_tready;
  assign xfer     = s_tvalid && s_tready;
  assign is_full  = (count == CntW'(DEPTH));
  assign is_empty = (count == '0);

  assign op.enq   = xfer && (req_type == REQ_ENQ) && !is_full;
  assign op.deq   = xfer && (req_type == REQ_DEQ) && !is_empty;
  assign op.value = data_in;
  assign op.pri   = priority_in;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    entry_t left_e;
    entry_t right_e;
    logic   left_k;
    if (i == 0) begin : g_first
      assign left_e = '0;
      assign left_k = 1'b1;
    end else begin : g_mid
      assign left_e = ents[i-1];
      assign left_k = keeps[i-1];
    end
    if (i == DEPTH - 1) begin : g_last
      assign right_e = '0;
    end else begin : g_inner
      assign right_e = ents[i+1];
    end
    spq_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .op        (op),
      .left      (left_e),
      .left_keep (left_k),
      .right     (right_e),
      .ent       (ents[i]),
      .keep      (keeps[i])
    );
    assign open_slot[i] = ents[i].valid && !keeps[i];
  end

  // newcomer lands behind every held entry
  assign at_end = (open_slot == '0);

  always_comb begin
    count_next   = count;
    tail_next    = tail;
    removed_next = '0;
    status_next  = ST_OK;
    if (req_type == REQ_ENQ) begin
      if (is_full) begin
        status_next = ST_FULL;
      end else begin
        count_next = count + CntW'(1);
        if (at_end) begin
          tail_next = data_in;
        end
      end
    end else begin
      if (is_empty) begin
        status_next = ST_EMPTY;
      end else begin
        count_next   = count - CntW'(1);
        removed_next = ents[0].value;
      end
    end

    head_next = ents[0].value;
    if (op.enq && !keeps[0]) begin
      head_next = data_in;
    end else if (op.deq) begin
      head_next = ents[1].valid ? ents[1].value : NoneData;
    end
    if (count_next == '0) begin
      head_next = NoneData;
    end
  end

  always_ff @(posedge clk) begin
    if (xfer) begin
      tail         <= tail_next;
      removed_data <= removed_next;
      head_data    <= head_next;
      tail_data    <= (count_next == '0) ? NoneData : tail_next;
      occupancy    <= OccW'(count_next);
      status       <= status_next;
    end
    if (rst) begin
      count    <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if (xfer) begin
        count <= count_next;
      end
      if (xfer) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  assign m_tdata = {3'b000, occupancy, tail_data, head_data, removed_data};
  assign m_tuser = status;

endmodule

// ===== hw/rtl/spq_cell.sv =====
`timescale 1ns / 1ps
module spq_cell
  import spq_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  cell_op_t op,
  input  entry_t   left,
  input  logic     left_keep,
  input  entry_t   right,
  output entry_t   ent,
  output logic     keep
);

  entry_t ent_next;

  // a cell keeps its entry on insert when it ranks at or above the newcomer
  assign keep = ent.valid && (ent.pri >= op.pri);

  always_comb begin
    ent_next = ent;
    if (op.enq) begin
      if (!keep) begin
        if (left_keep) begin
          ent_next.valid = 1'b1;
          ent_next.value = op.value;
          ent_next.pri   = op.pri;
        end else begin
          ent_next = left;
        end
      end
    end else if (op.deq) begin
      ent_next = right;
    end
  end

  always_ff @(posedge clk) begin
    ent.value <= ent_next.value;
    ent.pri   <= ent_next.pri;
    if (rst) begin
      ent.valid <= 1'b0;
    end else begin
      ent.valid <= ent_next.valid;
    end
  end

endmodule

// ===== hw/rtl/spq_checker.sv =====
`timescale 1ns / 1ps
module spq_checker
  import spq_pkg::*;
(
  input logic         clk,
  input logic         rst,
  input logic         s_tvalid,
  input logic         s_tready,
  input logic         m_tvalid,
  input logic         m_tready,
  input logic [103:0] m_tdata,
  input logic [1:0]   m_tuser
);

  // a stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("result changed while stalled");

  // every request transfer yields a result next cycle
  a_result: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> m_tvalid)
    else $error("request transfer without result");

  // an empty output slot never blocks requests
  a_ready: assert property (@(posedge clk) disable iff (rst)
    !m_tvalid |-> s_tready)
    else $error("input stalled with no pending result");

  // an empty queue reports no head and no tail
  a_empty: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tdata[100:96] == 5'd0) |->
      (m_tdata[63:32] == NoneData) && (m_tdata[95:64] == NoneData))
    else $error("empty queue reports head or tail data");

  // a dequeue on an empty queue removes nothing and leaves it empty
  a_deq_empty: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tuser == ST_EMPTY) |->
      (m_tdata[31:0] == '0) && (m_tdata[100:96] == 5'd0))
    else $error("empty status with data or occupancy");

endmodule

bind sorted_priority_queue spq_checker u_spq_checker (.*);
